>>> hdl/assert_macros.svh
// Shared assertion macros for the note-length parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/mnlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mnlp_pkg;

   // Divider operand width (whole-note tick count and divisor both fit a byte)
   localparam int DIV_W = 8;

   // Character codes
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;

   // Request action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_CHAR  = 1'b1;

   // Triplet rounding: floor(x / 6) = (x * TRIP_RECIP) >> TRIP_SHIFT for x < 2048
   localparam logic [15:0] TRIP_RECIP = 16'd43691;
   localparam int          TRIP_SHIFT = 18;

   localparam logic [15:0] ACC_MAX = 16'hFFFF;

   typedef struct packed {
      logic       action;
      logic [7:0] ch;
      logic [7:0] default_length;
      logic       triplet_mode;
   } req_type;

   typedef struct packed {
      logic [15:0] ticks;
      logic        length_error;
      logic [7:0]  terminator;
   } rsp_type;

   // Token parse phase
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_EQUALS = 2'd2,
      PH_DOTS   = 2'd3
   } phase_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_LOAD   = 2'd2,
      ST_FINISH = 2'd3
   } ctl_state_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic accept;
      logic div_start;
      logic load_base;
      logic finish;
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic needs_div;
      logic div_done;
      logic out_blocked;
   } sts_type;

endpackage

`default_nettype wire

>>> hdl/mml_note_length_parser_top.sv
// Note-length token parser for music macro text.
// Request channel (req_valid / req_stall / req_data): action 0 opens a token and
// latches default_length and triplet_mode; action 1 delivers one character.
// Response channel (rsp_valid / rsp_stall / rsp_data): one result per finished
// token with ticks, length_error and the terminating character (not consumed).
// Start requests, digits, '=' and later dots update the token state directly. The
// first non-digit after the digits of a plain-form token starts a bit-serial
// divide of the whole-note tick count; a load step then sets the base length
// and a finish step applies that character.
// A result appears in the output register the cycle after the request that
// ends the token, or after a finish step that applies the terminator.
// Synchronous active-high reset empties the output register and leaves the
// parser idle; characters arriving while idle are dropped.
// While a result waits under rsp_stall, req_stall is high and no request is
// taken. req_stall also stays high from the cycle after a divide starts until
// the finish step has applied the pending character.
`timescale 1ns / 1ps
`default_nettype none

module mml_note_length_parser_top #(
   parameter int WHOLE_NOTE_TICKS = 192
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mnlp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mnlp_pkg::rsp_type      rsp_data
);
   import mnlp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mnlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mnlp_dp #(
      .WHOLE_NOTE_TICKS (WHOLE_NOTE_TICKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hdl/mnlp_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mnlp_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mnlp_pkg::DIV_W-1:0] dividend,
   input  wire logic [mnlp_pkg::DIV_W-1:0] divisor,
   output logic                           done,
   output logic      [mnlp_pkg::DIV_W-1:0] quotient
);
   import mnlp_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     trial_diff;
   logic               trial_ge;

   // One restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      trial      = {rem_ff, quo_ff[DIV_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      trial_ge   = (trial >= {1'b0, div_ff});
   end

   assign done     = busy_ff && (cnt_ff == CNT_W'(DIV_W - 1));
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         rem_in = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], trial_ge};
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   `CHK_NEXT(a_div_rem_lt, clock, reset, done, rem_ff < div_ff, "divider remainder not below divisor")
   `CHK_NEXT(a_div_idle, clock, reset, done && !start, !busy_ff, "divider still busy after last step")

endmodule

`default_nettype wire

>>> hdl/mnlp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mnlp_dp #(
   parameter int WHOLE_NOTE_TICKS = 192
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mnlp_pkg::req_type req_data,
   input  wire logic              rsp_stall,
   input  wire mnlp_pkg::cmd_type cmd,
   output mnlp_pkg::sts_type      sts,
   output logic                   rsp_valid,
   output mnlp_pkg::rsp_type      rsp_data
);
   import mnlp_pkg::*;

   // Token state
   phase_type          phase_ff, phase_in;
   logic [15:0]        acc_ff, acc_in;
   logic               seen_ff, seen_in;
   logic [8:0]         tick_sum_ff, tick_sum_in;
   logic [7:0]         dot_inc_ff, dot_inc_in;
   logic               trip_ff, trip_in;
   logic [7:0]         default_ff, default_in;
   logic [7:0]         pend_ch_ff, pend_ch_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [7:0]         cur_ch;
   logic               cur_digit;
   logic               req_digit;
   logic [3:0]         digit_val;
   logic [19:0]        acc_x10;
   logic [19:0]        acc_sum;
   logic [15:0]        acc_sat;
   logic [10:0]        trip_x;
   logic [26:0]        trip_prod;
   logic [8:0]         trip_q;
   logic [7:0]         half_inc;
   logic [8:0]         dot_sum;
   logic               acc_ok;
   logic [7:0]         div_sel;
   logic [7:0]         div_sel_nz;
   logic               div_done;
   logic [7:0]         quotient;

   // Character under work: the pending character in the finish step
   always_comb begin
      cur_ch    = cmd.finish ? pend_ch_ff : req_data.ch;
      cur_digit = (cur_ch >= CHAR_ZERO) && (cur_ch <= CHAR_NINE);
      req_digit = (req_data.ch >= CHAR_ZERO) && (req_data.ch <= CHAR_NINE);
      digit_val = cur_ch[3:0];
   end

   // Decimal accumulate, saturating at 16 bits
   always_comb begin
      acc_x10 = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1);
      acc_sum = acc_x10 + {16'b0, digit_val};
      acc_sat = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[15:0];
   end

   // Triplet rounding (4t+3)/6 by reciprocal multiply
   always_comb begin
      trip_x    = {tick_sum_ff, 2'b00} + 11'd3;
      trip_prod = 27'(trip_x) * 27'(TRIP_RECIP);
      trip_q    = trip_prod[TRIP_SHIFT +: 9];
   end

   // Dot extension
   always_comb begin
      half_inc = dot_inc_ff >> 1;
      dot_sum  = tick_sum_ff + {1'b0, half_inc};
   end

   // Divisor choice: collected value if in range, else the default; never zero
   always_comb begin
      acc_ok     = seen_ff && (acc_ff != 16'd0) && (acc_ff <= 16'(WHOLE_NOTE_TICKS));
      div_sel    = acc_ok ? acc_ff[7:0] : default_ff;
      div_sel_nz = (div_sel == 8'd0) ? 8'd1 : div_sel;
   end

   mnlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (DIV_W'(WHOLE_NOTE_TICKS)),
      .divisor  (div_sel_nz),
      .done     (div_done),
      .quotient (quotient)
   );

   // Status to the controller
   always_comb begin
      sts.needs_div   = (req_data.action == ACT_CHAR) && (phase_ff == PH_DIGITS) &&
                        !req_digit && !((req_data.ch == CHAR_EQUALS) && !seen_ff);
      sts.div_done    = div_done;
      sts.out_blocked = rsp_valid_ff && rsp_stall;
   end

   // Token state update and result formation
   always_comb begin
      logic    emit;
      rsp_type res;
      emit        = 1'b0;
      res         = rsp_data_ff;
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      tick_sum_in = tick_sum_ff;
      dot_inc_in  = dot_inc_ff;
      trip_in     = trip_ff;
      default_in  = default_ff;
      pend_ch_in  = pend_ch_ff;

      if (cmd.accept && (req_data.action == ACT_START)) begin
         phase_in    = PH_DIGITS;
         acc_in      = '0;
         seen_in     = 1'b0;
         tick_sum_in = '0;
         dot_inc_in  = '0;
         default_in  = req_data.default_length;
         trip_in     = req_data.triplet_mode;
      end else if (cmd.accept || cmd.finish) begin
         case (cmd.finish ? PH_DOTS : phase_ff)
            PH_DIGITS: begin
               if (cur_digit) begin
                  acc_in  = acc_sat;
                  seen_in = 1'b1;
               end else if ((cur_ch == CHAR_EQUALS) && !seen_ff) begin
                  phase_in = PH_EQUALS;
                  acc_in   = '0;
                  seen_in  = 1'b0;
               end else begin
                  // divider runs; this char is replayed in the finish step
                  pend_ch_in = cur_ch;
               end
            end
            PH_EQUALS: begin
               if (cur_digit) begin
                  acc_in  = acc_sat;
                  seen_in = 1'b1;
               end else begin
                  emit             = 1'b1;
                  res.ticks        = seen_ff ? acc_ff : 16'd0;
                  res.length_error = !seen_ff;
                  res.terminator   = cur_ch;
                  phase_in         = PH_IDLE;
               end
            end
            PH_DOTS: begin
               if (cur_ch == CHAR_DOT) begin
                  dot_inc_in  = half_inc;
                  tick_sum_in = dot_sum;
               end else begin
                  emit             = 1'b1;
                  res.ticks        = trip_ff ? 16'(trip_q) : 16'(tick_sum_ff);
                  res.length_error = 1'b0;
                  res.terminator   = cur_ch;
                  phase_in         = PH_IDLE;
               end
            end
            default: begin
               // character while idle is dropped
            end
         endcase
      end

      // Quotient becomes the base length and first increment
      if (cmd.load_base) begin
         tick_sum_in = {1'b0, quotient};
         dot_inc_in  = quotient;
         phase_in    = PH_DOTS;
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = emit ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         tick_sum_ff  <= '0;
         dot_inc_ff   <= '0;
         trip_ff      <= 1'b0;
         default_ff   <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         tick_sum_ff  <= tick_sum_in;
         dot_inc_ff   <= dot_inc_in;
         trip_ff      <= trip_in;
         default_ff   <= default_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ch_ff  <= pend_ch_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CHK_IMPL(a_dp_err_zero, clock, reset, rsp_valid_ff && rsp_data_ff.length_error, rsp_data_ff.ticks == 16'd0, "error result with nonzero ticks")
   `CHK_NEXT(a_dp_load_dots, clock, reset, cmd.load_base, phase_ff == PH_DOTS, "base load did not enter dots phase")

endmodule

`default_nettype wire

>>> hdl/mnlp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mnlp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mnlp_pkg::sts_type sts,
   output mnlp_pkg::cmd_type      cmd
);
   import mnlp_pkg::*;

   ctl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (req_valid && !sts.out_blocked && sts.needs_div) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.out_blocked) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_ACCEPT: begin
            req_stall     = sts.out_blocked;
            cmd.accept    = req_valid && !sts.out_blocked;
            cmd.div_start = req_valid && !sts.out_blocked && sts.needs_div;
         end
         ST_DIVIDE: begin
         end
         ST_LOAD: begin
            cmd.load_base = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = !sts.out_blocked;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   `CHK_IMPL(a_ctl_done_in_div, clock, reset, sts.div_done, state_ff == ST_DIVIDE, "divider done outside divide state")
   `CHK_NEXT(a_ctl_start_div, clock, reset, cmd.div_start, state_ff == ST_DIVIDE, "divide start did not enter divide state")

endmodule

`default_nettype wire
